// ----- rtl/core/great_circle_distance_assert.svh -----
// ---------------------------------------------------------------------------
// Great-circle distance assertion macros
// Shared property forms for the distance pipeline checks.
// ---------------------------------------------------------------------------
`ifndef GREAT_CIRCLE_DISTANCE_ASSERT_SVH
`define GREAT_CIRCLE_DISTANCE_ASSERT_SVH

// same-cycle implication, off during reset
`define GCD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("great_circle_distance: implication check failed");

// next-cycle implication, active during reset
`define GCD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("great_circle_distance: next-cycle check failed");

`endif

// ----- rtl/core/gcd_pkg.sv -----
// ---------------------------------------------------------------------------
// Great-circle distance package
// Turn constants, CORDIC mode type and elaboration-time constant builders.
// ---------------------------------------------------------------------------
package gcd_pkg;

  typedef enum logic {
    CORDIC_ROTATE,
    CORDIC_VECTOR
  } cordic_mode_t;

  localparam logic [32:0] DEG7_HALF_TURN    = 33'd1800000000;
  localparam logic [32:0] DEG7_FULL_TURN    = 33'd3600000000;
  localparam logic [32:0] DEG7_QUARTER_TURN = 33'd900000000;
  localparam logic [63:0] ONE62             = 64'd1 << 62;
  localparam logic [33:0] DIST_MAX          = 34'h07FFFFFFF;

  // long division, returns {quotient, remainder}
  function automatic logic [127:0] udivmod(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return {q, r[63:0]};
  endfunction

  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [127:0] qr;
    qr = udivmod(num, den);
    return qr[127:64];
  endfunction

  function automatic logic [63:0] umod(input logic [63:0] num, input logic [63:0] den);
    logic [127:0] qr;
    qr = udivmod(num, den);
    return qr[63:0];
  endfunction

  // atan(1/n) at 62 fractional bits by its power series
  function automatic logic [63:0] atan_recip(input logic [63:0] n);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] term;
    p = udiv(ONE62, n);
    sum = '0;
    for (int k = 0; k < 48; k++) begin
      if (p != 0) begin
        term = udiv(p, 64'(2 * k + 1));
        if (k[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
        p = udiv(udiv(p, n), n);
      end
    end
    return sum;
  endfunction

  function automatic logic [63:0] atan62(input int i);
    logic [63:0] r;
    if (i == 0) begin
      r = 64'd4 * atan_recip(64'd5) - atan_recip(64'd239);
    end else begin
      r = atan_recip(64'd1 << (i < 62 ? i : 62));
    end
    return r;
  endfunction

  function automatic logic [63:0] atan_frac(input int i, input int frac);
    return atan62(i) >> (62 - frac);
  endfunction

  function automatic logic [63:0] isqrt_c(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v = val;
    res = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // inverse CORDIC gain at 62 fractional bits for a given iteration count
  function automatic logic [63:0] kinv62(input int iters);
    logic [63:0] g2;
    logic [63:0] s;
    logic [63:0] q;
    logic [63:0] r;
    g2 = 64'd1 << 60;
    for (int i = 0; i < 64; i++) begin
      if (i < iters) begin
        if (i == 0) begin
          g2 = g2 + g2;
        end else if (2 * i < 64) begin
          g2 = g2 + (g2 >> (2 * i));
        end
      end
    end
    s = isqrt_c(g2);
    q = udiv(ONE62, s);
    r = umod(ONE62, s);
    return (q << 30) + udiv(r << 30, s);
  endfunction

  function automatic logic [63:0] pi62_calc();
    return 64'd4 * atan62(0);
  endfunction

  function automatic logic [63:0] deg_to_rad93_calc();
    logic [63:0] pv;
    logic [63:0] q;
    logic [63:0] r;
    pv = pi62_calc();
    q = udiv(pv, 64'(DEG7_HALF_TURN));
    r = umod(pv, 64'(DEG7_HALF_TURN));
    return (q << 31) + udiv(r << 31, 64'(DEG7_HALF_TURN));
  endfunction

  localparam logic [63:0] PI62  = pi62_calc();
  localparam logic [63:0] D2R93 = deg_to_rad93_calc();

endpackage

// ----- rtl/core/gcd_mulshr.sv -----
// ---------------------------------------------------------------------------
// Split multiplier with truncating shift
// Four registered partial products, then sum, shift right and truncate.
// ---------------------------------------------------------------------------
module gcd_mulshr #(
  parameter int AW = 31,
  parameter int BW = 64,
  parameter int SH = 64,
  parameter int OW = 34
) (
  input  logic          clk,
  input  logic          en,
  input  logic [AW-1:0] a,
  input  logic [BW-1:0] b,
  output logic [OW-1:0] p
);

  localparam int AL = (AW + 1) / 2;
  localparam int AH = AW - AL;
  localparam int BL = (BW + 1) / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic [AL+BL-1:0] pll;
  logic [AL+BH-1:0] plh;
  logic [AH+BL-1:0] phl;
  logic [AH+BH-1:0] phh;
  logic [PW-1:0]    prod;

  always_ff @(posedge clk) begin
    if (en) begin
      pll <= a[AL-1:0] * b[BL-1:0];
      plh <= a[AL-1:0] * b[BW-1:BL];
      phl <= a[AW-1:AL] * b[BL-1:0];
      phh <= a[AW-1:AL] * b[BW-1:BL];
    end
  end

  always_comb begin
    prod = (PW'(phh) << (AL + BL)) + (PW'(phl) << AL) + (PW'(plh) << BL) + PW'(pll);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= OW'(prod >> SH);
    end
  end

endmodule

// ----- rtl/core/gcd_cordic_cell.sv -----
// ---------------------------------------------------------------------------
// CORDIC cell
// One registered micro-rotation, rotation or vectoring mode.
// ---------------------------------------------------------------------------
module gcd_cordic_cell #(
  parameter gcd_pkg::cordic_mode_t MODE = gcd_pkg::CORDIC_ROTATE,
  parameter int                    I    = 0,
  parameter int                    W    = 33,
  parameter int                    ZW   = 33,
  parameter logic signed [ZW-1:0]  ATAN = '0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [W-1:0]  x_in,
  input  logic signed [W-1:0]  y_in,
  input  logic signed [ZW-1:0] z_in,
  output logic signed [W-1:0]  x_out,
  output logic signed [W-1:0]  y_out,
  output logic signed [ZW-1:0] z_out
);

  import gcd_pkg::*;

  logic signed [W-1:0]  dx;
  logic signed [W-1:0]  dy;
  logic                 up;
  logic signed [W-1:0]  x_next;
  logic signed [W-1:0]  y_next;
  logic signed [ZW-1:0] z_next;

  always_comb begin
    dx = y_in >>> I;
    dy = x_in >>> I;
    if (MODE == CORDIC_ROTATE) begin
      up = !z_in[ZW-1];
    end else begin
      up = !(!y_in[W-1] && (y_in != '0));
    end
    if (up) begin
      x_next = x_in - dx;
      y_next = y_in + dy;
      z_next = z_in - ATAN;
    end else begin
      x_next = x_in + dx;
      y_next = y_in - dy;
      z_next = z_in + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out <= x_next;
      y_out <= y_next;
      z_out <= z_next;
    end
  end

endmodule

// ----- rtl/core/gcd_sqrt_cell.sv -----
// ---------------------------------------------------------------------------
// Square root cell
// One registered step of the bitwise integer square root.
// ---------------------------------------------------------------------------
module gcd_sqrt_cell #(
  parameter int K = 0
) (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] v_in,
  input  logic [63:0] res_in,
  output logic [63:0] v_out,
  output logic [63:0] res_out
);

  localparam logic [63:0] BITV = 64'd1 << (62 - 2 * K);

  logic [63:0] trial;
  logic [63:0] v_next;
  logic [63:0] res_next;

  always_comb begin
    trial = res_in + BITV;
    if (v_in >= trial) begin
      v_next   = v_in - trial;
      res_next = (res_in >> 1) + BITV;
    end else begin
      v_next   = v_in;
      res_next = res_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_out   <= v_next;
      res_out <= res_next;
    end
  end

endmodule

// ----- rtl/core/great_circle_distance.sv -----
// Throughput: one transaction per cycle while the output is not stalled; every CORDIC iteration
// and square root step is its own cell, so the chains of cells set the latency and never the rate.
// Reset clears the valid pipeline and loads a radius of 6371000 m.
// ---------------------------------------------------------------------------
// Great-circle distance
// Haversine distance between two points by CORDIC and square root cell chains.
// ---------------------------------------------------------------------------
`include "great_circle_distance_assert.svh"

module great_circle_distance #(
  parameter int CORDIC_ITERATIONS = 24,
  parameter int ANGLE_FRAC_BITS   = 30
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [30:0] lat_a,
  input  logic signed [31:0] lon_a,
  input  logic signed [30:0] lat_b,
  input  logic signed [31:0] lon_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [30:0]        distance_cm,
  input  logic               cfg_wr_en,
  input  logic [22:0]        cfg_wr_data
);

  import gcd_pkg::*;

  localparam int N     = CORDIC_ITERATIONS;
  localparam int F     = ANGLE_FRAC_BITS;
  localparam int XW    = F + 3;
  localparam int ZW    = F + 3;
  localparam int TW    = F + 2;
  localparam int VW    = 35;
  localparam int LAT   = 47 + 2 * N;
  localparam int A_IDX = N + 9;
  localparam logic signed [XW-1:0] KINV = XW'(kinv62(N) >> (62 - F));
  localparam logic [F:0]           ONE  = (F + 1)'(1) << F;

  logic           en;
  logic [LAT-1:0] vld;
  logic [29:0]    rcm;

  assign en        = !(vld[LAT-1] && out_stall);
  assign in_stall  = vld[LAT-1] && out_stall;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rcm <= 30'd637100000;
    end else if (cfg_wr_en) begin
      rcm <= 30'(cfg_wr_data) * 30'd100;
    end
  end

  // differences and magnitudes
  logic signed [31:0] dlat;
  logic signed [32:0] dlon;
  logic [31:0]        dlat_m;
  logic [32:0]        dlon_m;
  logic [30:0]        la_m;
  logic [30:0]        lb_m;

  always_comb begin
    dlat = 32'(lat_a) - 32'(lat_b);
    dlon = 33'(lon_a) - 33'(lon_b);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dlat_m <= dlat[31] ? 32'(-dlat) : 32'(dlat);
      dlon_m <= dlon[32] ? 33'(-dlon) : 33'(dlon);
      la_m   <= lat_a[30] ? 31'(-lat_a) : 31'(lat_a);
      lb_m   <= lat_b[30] ? 31'(-lat_b) : 31'(lat_b);
    end
  end

  // fold into the first half turn (sines) and quarter turn (cosines)
  logic [32:0] hs_raw [0:1];
  logic [32:0] hs_mod [0:1];
  logic [30:0] fold_next [0:3];
  logic [1:0]  lneg_next;
  logic [30:0] fold [0:3];
  logic [1:0]  lneg;

  always_comb begin
    hs_raw[0] = {1'b0, dlat_m};
    hs_raw[1] = dlon_m;
    for (int k = 0; k < 2; k++) begin
      hs_mod[k] = (hs_raw[k] >= DEG7_FULL_TURN) ? hs_raw[k] - DEG7_FULL_TURN : hs_raw[k];
      if (hs_mod[k] > DEG7_HALF_TURN) begin
        fold_next[k] = 31'(DEG7_FULL_TURN - hs_mod[k]);
      end else begin
        fold_next[k] = 31'(hs_mod[k]);
      end
    end
    if ({2'b00, la_m} > DEG7_QUARTER_TURN) begin
      fold_next[2] = 31'(DEG7_HALF_TURN - {2'b00, la_m});
      lneg_next[0] = 1'b1;
    end else begin
      fold_next[2] = la_m;
      lneg_next[0] = 1'b0;
    end
    if ({2'b00, lb_m} > DEG7_QUARTER_TURN) begin
      fold_next[3] = 31'(DEG7_HALF_TURN - {2'b00, lb_m});
      lneg_next[1] = 1'b1;
    end else begin
      fold_next[3] = lb_m;
      lneg_next[1] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fold <= fold_next;
      lneg <= lneg_next;
    end
  end

  // degrees to radians, then rotation chains
  logic [TW-1:0]        theta [0:3];
  logic signed [XW-1:0] rx [0:3][0:N];
  logic signed [XW-1:0] ry [0:3][0:N];
  logic signed [ZW-1:0] rz [0:3][0:N];

  for (genvar k = 0; k < 4; k++) begin : g_rot
    gcd_mulshr #(
      .AW(31), .BW(64), .SH(k < 2 ? 94 - F : 93 - F), .OW(TW)
    ) u_d2r (
      .clk(clk), .en(en), .a(fold[k]), .b(D2R93), .p(theta[k])
    );

    assign rx[k][0] = KINV;
    assign ry[k][0] = '0;
    assign rz[k][0] = {1'b0, theta[k]};

    for (genvar i = 0; i < N; i++) begin : g_cell
      gcd_cordic_cell #(
        .MODE(CORDIC_ROTATE), .I(i), .W(XW), .ZW(ZW), .ATAN(ZW'(atan_frac(i, F)))
      ) u_cell (
        .clk(clk), .en(en),
        .x_in(rx[k][i]), .y_in(ry[k][i]), .z_in(rz[k][i]),
        .x_out(rx[k][i+1]), .y_out(ry[k][i+1]), .z_out(rz[k][i+1])
      );
    end
  end

  logic [1:0] lneg_line [0:N+1];

  always_ff @(posedge clk) begin
    if (en) begin
      lneg_line[0] <= lneg;
      for (int j = 1; j < N + 2; j++) begin
        lneg_line[j] <= lneg_line[j-1];
      end
    end
  end

  // magnitudes and sign of the cross term
  logic [TW-1:0] s1;
  logic [TW-1:0] s2;
  logic [TW-1:0] ca;
  logic [TW-1:0] cb;
  logic          nd;

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= ry[0][N][XW-1] ? TW'(-ry[0][N]) : TW'(ry[0][N]);
      s2 <= ry[1][N][XW-1] ? TW'(-ry[1][N]) : TW'(ry[1][N]);
      ca <= rx[2][N][XW-1] ? TW'(-rx[2][N]) : TW'(rx[2][N]);
      cb <= rx[3][N][XW-1] ? TW'(-rx[3][N]) : TW'(rx[3][N]);
      nd <= lneg_line[N+1][0] ^ lneg_line[N+1][1] ^ rx[2][N][XW-1] ^ rx[3][N][XW-1];
    end
  end

  logic [TW-1:0] t1;
  logic [TW-1:0] pc;
  logic [TW-1:0] qs;
  logic [TW-1:0] t3;
  logic [TW-1:0] t1_line [0:1];
  logic          nd_line [0:3];

  gcd_mulshr #(.AW(TW), .BW(TW), .SH(F), .OW(TW)) u_t1 (
    .clk(clk), .en(en), .a(s1), .b(s1), .p(t1)
  );
  gcd_mulshr #(.AW(TW), .BW(TW), .SH(F), .OW(TW)) u_cc (
    .clk(clk), .en(en), .a(ca), .b(cb), .p(pc)
  );
  gcd_mulshr #(.AW(TW), .BW(TW), .SH(F), .OW(TW)) u_ss (
    .clk(clk), .en(en), .a(s2), .b(s2), .p(qs)
  );
  gcd_mulshr #(.AW(TW), .BW(TW), .SH(F), .OW(TW)) u_t3 (
    .clk(clk), .en(en), .a(pc), .b(qs), .p(t3)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      t1_line[0] <= t1;
      t1_line[1] <= t1_line[0];
      nd_line[0] <= nd;
      for (int j = 1; j < 4; j++) begin
        nd_line[j] <= nd_line[j-1];
      end
    end
  end

  // haversine term, clamped
  logic [TW:0] a_sum;
  logic [F:0]  a_next;
  logic [F:0]  a_q;

  always_comb begin
    if (nd_line[3]) begin
      a_sum = (t1_line[1] > t3) ? (TW + 1)'(t1_line[1] - t3) : '0;
    end else begin
      a_sum = (TW + 1)'(t1_line[1]) + (TW + 1)'(t3);
    end
    a_next = (a_sum > (TW + 1)'(ONE)) ? ONE : a_sum[F:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_q <= a_next;
    end
  end

  // square root chains
  logic [63:0] sv_head [0:1];
  logic [63:0] sv [0:1][0:32];
  logic [63:0] sr [0:1][0:32];

  always_ff @(posedge clk) begin
    if (en) begin
      sv_head[0] <= 64'(a_q) << (62 - F);
      sv_head[1] <= 64'(ONE - a_q) << (62 - F);
    end
  end

  for (genvar j = 0; j < 2; j++) begin : g_sqrt
    assign sv[j][0] = sv_head[j];
    assign sr[j][0] = '0;
    for (genvar i = 0; i < 32; i++) begin : g_cell
      gcd_sqrt_cell #(.K(i)) u_cell (
        .clk(clk), .en(en),
        .v_in(sv[j][i]), .res_in(sr[j][i]),
        .v_out(sv[j][i+1]), .res_out(sr[j][i+1])
      );
    end
  end

  // central half angle by vectoring chain
  logic signed [VW-1:0] vx [0:N];
  logic signed [VW-1:0] vy [0:N];
  logic signed [ZW-1:0] vz [0:N];

  assign vx[0] = {2'b00, sr[1][32][32:0]};
  assign vy[0] = {2'b00, sr[0][32][32:0]};
  assign vz[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_vec
    gcd_cordic_cell #(
      .MODE(CORDIC_VECTOR), .I(i), .W(VW), .ZW(ZW), .ATAN(ZW'(atan_frac(i, F)))
    ) u_cell (
      .clk(clk), .en(en),
      .x_in(vx[i]), .y_in(vy[i]), .z_in(vz[i]),
      .x_out(vx[i+1]), .y_out(vy[i+1]), .z_out(vz[i+1])
    );
  end

  logic [ZW-1:0] ang2;

  always_ff @(posedge clk) begin
    if (en) begin
      ang2 <= vz[N][ZW-1] ? '0 : {vz[N][ZW-2:0], 1'b0};
    end
  end

  // scale by radius, saturate
  logic [33:0] dist_raw;
  logic [33:0] cap;
  logic [33:0] dmin;
  logic [30:0] distance_next;

  gcd_mulshr #(.AW(30), .BW(ZW), .SH(F), .OW(34)) u_dist (
    .clk(clk), .en(en), .a(rcm), .b(ang2), .p(dist_raw)
  );
  gcd_mulshr #(.AW(30), .BW(64), .SH(62), .OW(34)) u_cap (
    .clk(clk), .en(en), .a(rcm), .b(PI62), .p(cap)
  );

  always_comb begin
    dmin = (dist_raw > cap) ? cap : dist_raw;
    distance_next = (dmin > DIST_MAX) ? '1 : dmin[30:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      distance_cm <= distance_next;
    end
  end

  `GCD_ASSERT_NXT(a_rst_clears_out, rst, !out_valid)
  `GCD_ASSERT_IMP(a_no_stall_when_empty, !out_valid, !in_stall)
  `GCD_ASSERT_IMP(a_hav_clamped, vld[A_IDX], a_q <= ONE)

endmodule

// ----- bench/tb_great_circle_distance.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Great-circle distance testbench
// Drives point pairs through the distance pipeline under random bursts and
// receiver stalls, predicts each distance in fixed point and checks every
// output transaction in order. The sphere radius is changed between phases.
// ---------------------------------------------------------------------------

class distance_scoreboard;
  logic [30:0] expected_q[$];
  int          errors;

  function void note_pair(input logic [30:0] dist_exp);
    expected_q.push_back(dist_exp);
  endfunction

  function bit check_distance(input logic [30:0] got, output logic [30:0] want);
    if (expected_q.size() == 0) begin
      want = '0;
      return 1'b0;
    end
    want = expected_q.pop_front();
    return got == want;
  endfunction
endclass

module tb_great_circle_distance;
  import gcd_pkg::*;

  localparam int ITERS      = 24;
  localparam int FB         = 30;
  localparam int LATENCY    = 47 + 2 * ITERS;
  localparam int WATCH_LIMIT = 20000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [30:0] lat_a = '0;
  logic signed [31:0] lon_a = '0;
  logic signed [30:0] lat_b = '0;
  logic signed [31:0] lon_b = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [30:0]        distance_cm;
  logic               cfg_wr_en = 1'b0;
  logic [22:0]        cfg_wr_data = '0;

  distance_scoreboard sb;
  logic [22:0]        radius_m;
  logic [63:0]        atan_tab[64];
  logic [63:0]        kinv_fix;
  int                 idle_cycles;
  bit                 stall_mode;

  always #6 clk = ~clk;

  great_circle_distance i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .lat_a(lat_a), .lon_a(lon_a), .lat_b(lat_b), .lon_b(lon_b),
    .out_valid(out_valid), .out_stall(out_stall), .distance_cm(distance_cm),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  function automatic logic [63:0] mul_trunc(input logic [63:0] a, input logic [63:0] b,
                                           input int sh);
    logic [127:0] p;
    p = a * b;
    return 64'(p >> sh);
  endfunction

  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bt;
    logic [63:0] r;
    r = v;
    res = '0;
    bt = 64'd1 << 62;
    while (bt != 0) begin
      if (r >= res + bt) begin
        r = r - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] atan_series(input logic [63:0] n);
    logic [63:0] p;
    logic [63:0] sum;
    p = ((64'd1 << 62)) / n;
    sum = '0;
    for (int k = 0; k < 48 && p != 0; k++) begin
      if (k % 2 == 1) sum = sum - p / (2 * k + 1);
      else sum = sum + p / (2 * k + 1);
      p = p / n / n;
    end
    return sum;
  endfunction

  function automatic logic [63:0] pi_62();
    return 64'd4 * (64'd4 * atan_series(5) - atan_series(239));
  endfunction

  function automatic logic [63:0] d2r_93();
    logic [63:0] pv;
    pv = pi_62();
    return ((pv / 64'd1800000000) << 31) + (((pv % 64'd1800000000) << 31) / 64'd1800000000);
  endfunction

  function automatic logic signed [63:0] asr(input logic signed [63:0] v, input int s);
    return v >>> s;
  endfunction

  // rotation mode: gives cos and sin through the outputs c and s
  function automatic void rotate(input logic signed [63:0] theta,
                                 output logic signed [63:0] c, output logic signed [63:0] s);
    logic signed [63:0] x, y, z, dx, dy;
    x = kinv_fix;
    y = 0;
    z = theta;
    for (int i = 0; i < ITERS; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - signed'(atan_tab[i]);
      end else begin
        x = x + dx; y = y - dy; z = z + signed'(atan_tab[i]);
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic logic signed [63:0] vector_angle(input logic signed [63:0] yi,
                                                      input logic signed [63:0] xi);
    logic signed [63:0] x, y, z, dx, dy;
    x = xi;
    y = yi;
    z = 0;
    for (int i = 0; i < ITERS; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (y > 0) begin
        x = x + dx; y = y - dy; z = z + signed'(atan_tab[i]);
      end else begin
        x = x - dx; y = y + dy; z = z - signed'(atan_tab[i]);
      end
    end
    return z;
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] half_sine(input logic signed [63:0] d7);
    logic [63:0] m;
    logic signed [63:0] c, s;
    m = abs64(d7) % 64'd3600000000;
    if (m > 64'd1800000000) m = 64'd3600000000 - m;
    rotate(signed'(mul_trunc(m, d2r_93(), 94 - FB)), c, s);
    return abs64(s);
  endfunction

  function automatic logic [63:0] lat_cosine(input logic signed [63:0] lat7, output bit neg);
    logic [63:0] m;
    logic signed [63:0] c, s;
    m = abs64(lat7);
    neg = 1'b0;
    if (m > 64'd900000000) begin
      m = 64'd1800000000 - m;
      neg = 1'b1;
    end
    rotate(signed'(mul_trunc(m, d2r_93(), 93 - FB)), c, s);
    if (c < 0) neg = !neg;
    return abs64(c);
  endfunction

  function automatic logic [30:0] predict_distance(input logic signed [30:0] la,
      input logic signed [31:0] oa, input logic signed [30:0] lb, input logic signed [31:0] ob);
    logic [63:0] s1, s2, ca, cb, t1, t3, a, one, sa, sb, rcm, dist_cm, cap;
    logic signed [63:0] ang;
    bit na, nb;
    s1 = half_sine(64'(la) - 64'(lb));
    s2 = half_sine(64'(oa) - 64'(ob));
    ca = lat_cosine(64'(la), na);
    cb = lat_cosine(64'(lb), nb);
    t1 = mul_trunc(s1, s1, FB);
    t3 = mul_trunc(mul_trunc(ca, cb, FB), mul_trunc(s2, s2, FB), FB);
    if (na != nb) a = t1 > t3 ? t1 - t3 : 0;
    else a = t1 + t3;
    one = 64'd1 << FB;
    if (a > one) a = one;
    sa = root_floor(a << (62 - FB));
    sb = root_floor((one - a) << (62 - FB));
    ang = vector_angle(signed'(sa), signed'(sb));
    if (ang < 0) ang = 0;
    rcm = 64'(radius_m) * 100;
    dist_cm = mul_trunc(rcm, 2 * 64'(ang), FB);
    cap = mul_trunc(rcm, pi_62(), 62);
    if (dist_cm > cap) dist_cm = cap;
    if (dist_cm > 64'h7FFFFFFF) dist_cm = 64'h7FFFFFFF;
    return dist_cm[30:0];
  endfunction

  function automatic void build_tables();
    logic [63:0] g2, s;
    logic [63:0] k62;
    logic [63:0] one62;
    one62 = 64'd1 << 62;
    atan_tab[0] = (64'd4 * atan_series(5) - atan_series(239)) >> (62 - FB);
    for (int i = 1; i < 64; i++) atan_tab[i] = atan_series(64'd1 << (i < 62 ? i : 62)) >> (62 - FB);
    g2 = 64'd1 << 60;
    for (int i = 0; i < ITERS; i++) begin
      if (i == 0) g2 = g2 + g2;
      else if (2 * i < 64) g2 = g2 + (g2 >> (2 * i));
    end
    s = root_floor(g2);
    k62 = ((one62 / s) << 30) + (((one62 % s) << 30) / s);
    kinv_fix = k62 >> (62 - FB);
  endfunction

  task automatic report(input string what, input logic [30:0] got, input logic [30:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    sb.errors++;
  endtask

  // output side: check and stall pattern
  always @(posedge clk) begin
    logic [30:0] want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (sb.expected_q.size() == 0) report("unexpected transaction", distance_cm, '0);
        else if (!sb.check_distance(distance_cm, want)) report("distance_cm", distance_cm, want);
      end
      if ($urandom_range(0, 199) == 0) stall_mode <= !stall_mode;
      out_stall <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCH_LIMIT) begin
      $display("tb_great_circle_distance: done, errors");
      $finish;
    end
  end

  task automatic send_pair(input logic signed [30:0] la, input logic signed [31:0] oa,
                           input logic signed [30:0] lb, input logic signed [31:0] ob);
    in_valid <= 1'b1;
    lat_a <= la;
    lon_a <= oa;
    lat_b <= lb;
    lon_b <= ob;
    sb.note_pair(predict_distance(la, oa, lb, ob));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pause_sender(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_radius(input logic [22:0] r);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= r;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    radius_m = r;
  endtask

  function automatic logic signed [30:0] rand_lat(input bit wide);
    if (wide) return 31'($urandom());
    return 31'($signed($urandom_range(0, 1800000000)) - 900000000);
  endfunction

  function automatic logic signed [31:0] rand_lon(input bit wide);
    if (wide) return 32'($urandom());
    return 32'($signed($urandom_range(0, 3600000000)) - 64'sd1800000000);
  endfunction

  task automatic random_phase(input int n);
    int burst;
    int sent;
    logic signed [30:0] la, lb;
    logic signed [31:0] oa, ob;
    sent = 0;
    while (sent < n) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      for (int k = 0; k < burst && sent < n; k++) begin
        la = rand_lat($urandom_range(0, 9) == 0);
        oa = rand_lon($urandom_range(0, 9) == 0);
        case ($urandom_range(0, 3))
          0: begin
            lb = la + 31'($signed($urandom_range(0, 2000)) - 1000);
            ob = oa + 32'($signed($urandom_range(0, 2000)) - 1000);
          end
          1: begin
            lb = -la;
            ob = oa + 32'sd1800000000 + 32'($signed($urandom_range(0, 200)) - 100);
          end
          default: begin
            lb = rand_lat($urandom_range(0, 9) == 0);
            ob = rand_lon($urandom_range(0, 9) == 0);
          end
        endcase
        send_pair(la, oa, lb, ob);
        sent++;
      end
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
    end
  endtask

  initial begin
    sb = new();
    radius_m = 23'd6371000;
    stall_mode = 1'b0;
    idle_cycles = 0;
    build_tables();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, antipodes, poles, wraps and full-range bits
    send_pair(0, 0, 0, 0);
    send_pair(900000000, 0, -900000000, 0);
    send_pair(0, 0, 0, 1800000000);
    send_pair(0, -1800000000, 0, 1800000000);
    send_pair(900000000, 123, 900000000, -456);
    send_pair(-900000000, 1800000000, 900000000, -1800000000);
    send_pair(450000000, 900000000, -450000000, -900000000);
    send_pair(31'sh3FFFFFFF, 32'sh7FFFFFFF, 31'sh40000000, 32'sh80000000);
    send_pair(31'sh40000000, 32'sh80000000, 31'sh3FFFFFFF, 32'sh7FFFFFFF);
    send_pair(-1, -1, 0, 0);
    send_pair(1000000000, 0, 1000000000, 0);
    send_pair(1, 1, 0, 0);
    send_pair(0, 0, 1, 0);
    send_pair(123456789, 987654321, 123456789, 987654322);
    send_pair(0, 1799999999, 0, -1799999999);
    send_pair(-899999999, 0, 899999999, 1800000000);
    pause_sender(3);

    drain();
    write_radius(23'd6000000);
    random_phase(300);
    // sender holds until everything has come out
    drain();
    write_radius(23'd6500000);
    send_pair(900000000, 0, -900000000, 0);
    random_phase(300);
    drain();
    write_radius(23'h7FFFFF);
    send_pair(0, 0, 0, 1800000000);
    random_phase(100);
    drain();
    write_radius(23'd0);
    send_pair(0, 0, 0, 1800000000);
    random_phase(50);
    drain();
    write_radius(23'($urandom_range(6000000, 6500000)));
    random_phase(200);
    drain();

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb_great_circle_distance: done, clean");
    end else begin
      $display("tb_great_circle_distance: done, errors");
    end
    $finish;
  end
endmodule
